FILE: rtl/core/tracker_row_sequencer_unit_defines.svh
// assertion macros shared by the sequencer rtl
`ifndef TRACKER_ROW_SEQUENCER_UNIT_DEFINES_SVH
`define TRACKER_ROW_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, checked on the rising edge of i_clk outside reset
`define TRS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on the rising edge of i_clk outside reset
`define TRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/trs_pkg.sv
`default_nettype none

package trs_pkg;

    // operation codes carried in the input tuser
    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_EFFECT    = 3'd1,
        OP_END_ROW   = 3'd2,
        OP_START     = 3'd3,
        OP_SET_TEMPO = 3'd4
    } t_opcode;

    // global effect kinds
    typedef enum logic [1:0] {
        FX_SPEED = 2'd0,
        FX_JUMP  = 2'd1,
        FX_SKIP  = 2'd2,
        FX_HALT  = 2'd3
    } t_effect;

    // register indexes on the configuration port
    localparam logic [1:0] REG_FRAME_RATE   = 2'd0;
    localparam logic [1:0] REG_PATTERN_ROWS = 2'd1;
    localparam logic [1:0] REG_FRAME_TOTAL  = 2'd2;
    localparam logic [1:0] REG_TEMPO_THR    = 2'd3;

    // arithmetic constants
    localparam logic [5:0] RELOAD_MUL  = 6'd60;
    localparam logic [4:0] STEP_MUL    = 5'd24;
    localparam int         DIV_BITS    = 13;
    localparam logic [3:0] DIV_LAST    = 4'(DIV_BITS - 1);

    // reset values
    localparam logic [7:0]  RST_FRAME_RATE   = 8'd60;
    localparam logic [8:0]  RST_PATTERN_ROWS = 9'd64;
    localparam logic [8:0]  RST_FRAME_TOTAL  = 9'd1;
    localparam logic [7:0]  RST_TEMPO_THR    = 8'd31;
    localparam logic [7:0]  RST_TEMPO        = 8'd150;
    localparam logic [7:0]  RST_SPEED        = 8'd6;
    localparam logic [12:0] RST_STEP         = 13'd600;

    // row and frame counts: zero acts as one, anything above 256 as 256
    function automatic logic [8:0] clamp_count(input logic [8:0] v);
        logic [8:0] r;
        if (v == 9'd0) begin
            r = 9'd1;
        end else if (v > 9'd256) begin
            r = 9'd256;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // saturate a widened accumulator value back to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v < -18'sd32768) begin
            r = -16'sd32768;
        end else if (v > 18'sd32767) begin
            r = 16'sd32767;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tracker_row_sequencer_unit.sv
`default_nettype none

// Tracker row sequencer: every input transfer gives exactly one result transfer carrying
// the row-due flag, the play position and the halted flag. Ticks, halt effects, ignored
// jumps, end-of-row items and undefined codes load the result register in the cycle
// after acceptance. Speed or tempo effects, set tempo, and jumps and skips that are not
// ignored go through a shared restoring divider that settles one quotient bit per cycle;
// start runs the divider twice (frame, then row modulo). The input side is ready only
// when the divider is idle and the result register is empty or being taken.
// Configuration is a four-register APB port.

`include "tracker_row_sequencer_unit_defines.svh"

module tracker_row_sequencer_unit
    import trs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // effect_param[7:0], start_frame[15:8], start_row[23:16], new_tempo[31:24],
    // new_speed[39:32]
    input  wire logic [39:0] i_s_tdata,
    // opcode[2:0], effect_kind[4:3]
    input  wire logic [4:0]  i_s_tuser,
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // play_frame[7:0], play_row[15:8]
    output logic [15:0]      o_m_tdata,
    // row_due[0], is_halted[1]
    output logic [1:0]       o_m_tuser,
    // configuration port
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    typedef enum logic [1:0] {
        DOP_STEP,
        DOP_JUMP,
        DOP_SFRAME,
        DOP_SROW
    } t_div_op;

    // input fields
    t_opcode     in_op;
    t_effect     in_kind;
    logic [7:0]  in_param;
    logic [7:0]  in_sframe;
    logic [7:0]  in_srow;
    logic [7:0]  in_ntempo;
    logic [7:0]  in_nspeed;

    assign in_op     = t_opcode'(i_s_tuser[2:0]);
    assign in_kind   = t_effect'(i_s_tuser[4:3]);
    assign in_param  = i_s_tdata[7:0];
    assign in_sframe = i_s_tdata[15:8];
    assign in_srow   = i_s_tdata[23:16];
    assign in_ntempo = i_s_tdata[31:24];
    assign in_nspeed = i_s_tdata[39:32];

    // registers
    t_state             r_state, n_state;
    t_div_op            r_dop, n_dop;
    logic [3:0]         r_cnt, n_cnt;
    logic [12:0]        r_quo, n_quo;
    logic [8:0]         r_rem, n_rem;
    logic [8:0]         r_dsr, n_dsr;
    logic [7:0]         r_srow_hold, n_srow_hold;

    logic [7:0]         r_frame_rate, n_frame_rate;
    logic [8:0]         r_pattern_rows, n_pattern_rows;
    logic [8:0]         r_frame_total, n_frame_total;
    logic [7:0]         r_tempo_thr, n_tempo_thr;

    logic [7:0]         r_cur_frame, n_cur_frame;
    logic [7:0]         r_cur_row, n_cur_row;
    logic [7:0]         r_pend_frame, n_pend_frame;
    logic [7:0]         r_pend_row, n_pend_row;
    logic               r_jump_pend, n_jump_pend;
    logic               r_halted, n_halted;
    logic [7:0]         r_tempo, n_tempo;
    logic [7:0]         r_speed, n_speed;
    logic signed [15:0] r_accum, n_accum;
    logic [12:0]        r_step, n_step;

    logic               r_out_valid, n_out_valid;
    logic               r_out_due, n_out_due;
    logic [7:0]         r_out_frame, n_out_frame;
    logic [7:0]         r_out_row, n_out_row;
    logic               r_out_halted, n_out_halted;

    // handshakes
    logic in_fire;
    logic out_fire;
    logic cfg_wr;

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign out_fire   = r_out_valid && i_m_tready;
    assign cfg_wr     = i_psel && i_penable && i_pwrite;
    assign o_pready   = 1'b1;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_row, r_out_frame};
    assign o_m_tuser  = {r_out_halted, r_out_due};

    // register read-back
    always_comb begin
        unique case (i_paddr[3:2])
            REG_FRAME_RATE:   o_prdata = {24'd0, r_frame_rate};
            REG_PATTERN_ROWS: o_prdata = {23'd0, r_pattern_rows};
            REG_FRAME_TOTAL:  o_prdata = {23'd0, r_frame_total};
            REG_TEMPO_THR:    o_prdata = {24'd0, r_tempo_thr};
        endcase
    end

    // shared divider: one restoring step per cycle
    logic [9:0]  div_trial;
    logic        div_ge;
    logic [9:0]  div_diff;
    logic [8:0]  div_rem_nx;
    logic [12:0] div_quo_nx;

    assign div_trial  = {r_rem, r_quo[12]};
    assign div_ge     = div_trial >= {1'b0, r_dsr};
    assign div_diff   = div_trial - {1'b0, r_dsr};
    assign div_rem_nx = div_ge ? div_diff[8:0] : div_trial[8:0];
    assign div_quo_nx = {r_quo[11:0], div_ge};

    // tick arithmetic: reload then step, each saturated
    logic [13:0]        reload_amt;
    logic signed [17:0] acc_ext;
    logic signed [15:0] acc_loaded;
    logic signed [15:0] acc_ticked;
    logic               acc_le_zero;

    assign reload_amt  = 14'(r_frame_rate) * 14'(RELOAD_MUL);
    assign acc_ext     = 18'(r_accum);
    assign acc_le_zero = r_accum <= 16'sd0;
    assign acc_loaded  = acc_le_zero ? sat16(acc_ext + $signed({4'd0, reload_amt}))
                                     : r_accum;
    assign acc_ticked  = sat16(18'(acc_loaded) - $signed({5'd0, r_step}));

    // position helpers
    logic [8:0] ft_clamp;
    logic [8:0] pr_clamp;
    logic [8:0] row_inc;
    logic [8:0] frame_inc;
    logic [8:0] jump_target;
    logic       jump_ignored;
    logic [7:0] fx_param;

    assign ft_clamp     = clamp_count(r_frame_total);
    assign pr_clamp     = clamp_count(r_pattern_rows);
    assign row_inc      = {1'b0, r_cur_row} + 9'd1;
    assign frame_inc    = {1'b0, r_cur_frame} + 9'd1;
    assign jump_target  = (in_kind == FX_SKIP) ? frame_inc : {1'b0, in_param};
    assign jump_ignored = (jump_target == {1'b0, r_cur_frame}) && (r_cur_row == 8'd0);
    assign fx_param     = (in_param == 8'd0) ? 8'd1 : in_param;

    // sequencer and state update
    always_comb begin
        logic finish;
        logic due;
        logic [7:0] sp;
        finish = 1'b0;
        due    = 1'b0;
        sp     = 8'd0;

        n_state        = r_state;
        n_dop          = r_dop;
        n_cnt          = r_cnt;
        n_quo          = r_quo;
        n_rem          = r_rem;
        n_dsr          = r_dsr;
        n_srow_hold    = r_srow_hold;
        n_frame_rate   = r_frame_rate;
        n_pattern_rows = r_pattern_rows;
        n_frame_total  = r_frame_total;
        n_tempo_thr    = r_tempo_thr;
        n_cur_frame    = r_cur_frame;
        n_cur_row      = r_cur_row;
        n_pend_frame   = r_pend_frame;
        n_pend_row     = r_pend_row;
        n_jump_pend    = r_jump_pend;
        n_halted       = r_halted;
        n_tempo        = r_tempo;
        n_speed        = r_speed;
        n_accum        = r_accum;
        n_step         = r_step;
        n_out_valid    = r_out_valid && !out_fire;
        n_out_due      = r_out_due;
        n_out_frame    = r_out_frame;
        n_out_row      = r_out_row;
        n_out_halted   = r_out_halted;

        // configuration writes
        if (cfg_wr) begin
            unique case (i_paddr[3:2])
                REG_FRAME_RATE:   n_frame_rate   = i_pwdata[7:0];
                REG_PATTERN_ROWS: n_pattern_rows = i_pwdata[8:0];
                REG_FRAME_TOTAL:  n_frame_total  = i_pwdata[8:0];
                REG_TEMPO_THR:    n_tempo_thr    = i_pwdata[7:0];
            endcase
        end

        if (r_state == S_DIV) begin
            // divider running
            if (r_cnt == 4'd0) begin
                unique case (r_dop)
                    DOP_STEP: begin
                        n_step = div_quo_nx;
                        finish = 1'b1;
                    end
                    DOP_JUMP: begin
                        n_pend_frame = div_rem_nx[7:0];
                        finish = 1'b1;
                    end
                    DOP_SFRAME: begin
                        // frame done, now reduce the start row
                        n_cur_frame = div_rem_nx[7:0];
                        n_dop = DOP_SROW;
                        n_quo = 13'(r_srow_hold);
                        n_rem = 9'd0;
                        n_dsr = pr_clamp;
                        n_cnt = DIV_LAST;
                    end
                    DOP_SROW: begin
                        n_cur_row = div_rem_nx[7:0];
                        finish = 1'b1;
                    end
                endcase
                if (finish) begin
                    n_state = S_IDLE;
                end
            end else begin
                n_cnt = r_cnt - 4'd1;
                n_quo = div_quo_nx;
                n_rem = div_rem_nx;
            end
        end else if (in_fire) begin
            unique case (in_op)
                OP_TICK: begin
                    if (!r_halted) begin
                        n_accum = acc_ticked;
                        due = acc_le_zero;
                    end
                    finish = 1'b1;
                end
                OP_EFFECT: begin
                    unique case (in_kind)
                        FX_SPEED: begin
                            if (fx_param > r_tempo_thr) begin
                                n_tempo = fx_param;
                            end else begin
                                n_speed = fx_param;
                            end
                            n_dop   = DOP_STEP;
                            n_quo   = 13'(n_tempo) * 13'(STEP_MUL);
                            n_rem   = 9'd0;
                            n_dsr   = {1'b0, n_speed};
                            n_cnt   = DIV_LAST;
                            n_state = S_DIV;
                        end
                        FX_JUMP, FX_SKIP: begin
                            if (!jump_ignored) begin
                                n_pend_row  = 8'd0;
                                n_jump_pend = 1'b1;
                                n_dop   = DOP_JUMP;
                                n_quo   = 13'(jump_target);
                                n_rem   = 9'd0;
                                n_dsr   = ft_clamp;
                                n_cnt   = DIV_LAST;
                                n_state = S_DIV;
                            end else begin
                                finish = 1'b1;
                            end
                            // skip sets the target row even when the jump is ignored
                            if (in_kind == FX_SKIP) begin
                                n_pend_row = in_param;
                            end
                        end
                        FX_HALT: begin
                            n_halted = 1'b1;
                            finish = 1'b1;
                        end
                    endcase
                end
                OP_END_ROW: begin
                    if (r_jump_pend) begin
                        n_cur_frame = r_pend_frame;
                        n_cur_row   = r_pend_row;
                        n_jump_pend = 1'b0;
                    end else if (row_inc >= pr_clamp) begin
                        n_cur_row   = 8'd0;
                        n_cur_frame = (frame_inc >= ft_clamp) ? 8'd0 : frame_inc[7:0];
                    end else begin
                        n_cur_row = row_inc[7:0];
                    end
                    finish = 1'b1;
                end
                OP_START: begin
                    n_jump_pend = 1'b0;
                    n_halted    = 1'b0;
                    n_srow_hold = in_srow;
                    n_dop   = DOP_SFRAME;
                    n_quo   = 13'(in_sframe);
                    n_rem   = 9'd0;
                    n_dsr   = ft_clamp;
                    n_cnt   = DIV_LAST;
                    n_state = S_DIV;
                end
                OP_SET_TEMPO: begin
                    sp = (in_nspeed == 8'd0) ? 8'd1 : in_nspeed;
                    n_tempo = in_ntempo;
                    n_speed = sp;
                    n_accum = 16'sd0;
                    n_dop   = DOP_STEP;
                    n_quo   = 13'(in_ntempo) * 13'(STEP_MUL);
                    n_rem   = 9'd0;
                    n_dsr   = {1'b0, sp};
                    n_cnt   = DIV_LAST;
                    n_state = S_DIV;
                end
                default: begin
                    // undefined codes only report the position and the halted flag
                    finish = 1'b1;
                end
            endcase
        end

        // load the result register
        if (finish) begin
            n_out_valid  = 1'b1;
            n_out_due    = due;
            n_out_frame  = n_cur_frame;
            n_out_row    = n_cur_row;
            n_out_halted = n_halted;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_dop          <= DOP_STEP;
            r_cnt          <= 4'd0;
            r_frame_rate   <= RST_FRAME_RATE;
            r_pattern_rows <= RST_PATTERN_ROWS;
            r_frame_total  <= RST_FRAME_TOTAL;
            r_tempo_thr    <= RST_TEMPO_THR;
            r_cur_frame    <= 8'd0;
            r_cur_row      <= 8'd0;
            r_pend_frame   <= 8'd0;
            r_pend_row     <= 8'd0;
            r_jump_pend    <= 1'b0;
            r_halted       <= 1'b0;
            r_tempo        <= RST_TEMPO;
            r_speed        <= RST_SPEED;
            r_accum        <= 16'sd0;
            r_step         <= RST_STEP;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_dop          <= n_dop;
            r_cnt          <= n_cnt;
            r_frame_rate   <= n_frame_rate;
            r_pattern_rows <= n_pattern_rows;
            r_frame_total  <= n_frame_total;
            r_tempo_thr    <= n_tempo_thr;
            r_cur_frame    <= n_cur_frame;
            r_cur_row      <= n_cur_row;
            r_pend_frame   <= n_pend_frame;
            r_pend_row     <= n_pend_row;
            r_jump_pend    <= n_jump_pend;
            r_halted       <= n_halted;
            r_tempo        <= n_tempo;
            r_speed        <= n_speed;
            r_accum        <= n_accum;
            r_step         <= n_step;
            r_out_valid    <= n_out_valid;
        end
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_dsr        <= n_dsr;
        r_srow_hold  <= n_srow_hold;
        r_out_due    <= n_out_due;
        r_out_frame  <= n_out_frame;
        r_out_row    <= n_out_row;
        r_out_halted <= n_out_halted;
    end

    // checks
    `TRS_ASSERT_IMP(a_div_no_result, r_state == S_DIV, !r_out_valid && !o_s_tready, "result pending while divider runs")
    `TRS_ASSERT_IMP(a_speed_nonzero, 1'b1, r_speed != 8'd0, "speed register holds zero")
    `TRS_ASSERT_NEXT(a_tick_one_cycle, in_fire && (in_op == OP_TICK), r_out_valid && (r_state == S_IDLE), "tick result not ready next cycle")

endmodule

`default_nettype wire

FILE: dv/tracker_row_sequencer_unit_tb.sv
`timescale 1ns / 1ps

module tracker_row_sequencer_unit_tb;
    import trs_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 255;
    localparam int MAX_WAIT     = 17;
    // highest opcode with no meaning
    localparam logic [2:0] OP_UNDEF_TOP = 3'd7;

    // register settings per phase: frame rate, pattern rows, frame total, tempo threshold
    localparam int PHASE_CFG [6][4] = '{
        '{255, 256, 256, 0},
        '{1, 1, 1, 255},
        '{0, 0, 0, 128},
        '{200, 511, 300, 31},
        '{17, 6, 5, 100},
        '{60, 12, 3, 31}
    };

    typedef struct {
        logic [2:0] opcode;
        t_effect    kind;
        logic [7:0] param;
        logic [7:0] sframe;
        logic [7:0] srow;
        logic [7:0] ntempo;
        logic [7:0] nspeed;
    } seq_cmd_t;

    typedef struct {
        logic       row_due;
        logic [7:0] frame;
        logic [7:0] row;
        logic       halted;
    } play_pos_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // effect_param, start_frame, start_row, new_tempo, new_speed
    logic [39:0] i_s_tdata  = '0;
    // opcode, effect_kind
    logic [4:0]  i_s_tuser  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // play_frame, play_row
    logic [15:0] o_m_tdata;
    // row_due, is_halted
    logic [1:0]  o_m_tuser;
    logic        i_psel     = 1'b0;
    logic        i_penable  = 1'b0;
    logic        i_pwrite   = 1'b0;
    logic [3:0]  i_paddr    = '0;
    logic [31:0] i_pwdata   = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    tracker_row_sequencer_unit DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // register copies
    int cfg_frame_rate  = int'(RST_FRAME_RATE);
    int cfg_rows        = int'(RST_PATTERN_ROWS);
    int cfg_frame_total = int'(RST_FRAME_TOTAL);
    int cfg_tempo_thr   = int'(RST_TEMPO_THR);

    // sequencer state as predicted
    logic [7:0] pos_frame  = '0;
    logic [7:0] pos_row    = '0;
    logic [7:0] pend_frame = '0;
    logic [7:0] pend_row   = '0;
    logic       jump_armed = 1'b0;
    logic       halted     = 1'b0;
    int         tempo      = int'(RST_TEMPO);
    int         speed      = int'(RST_SPEED);
    int         accum      = 0;
    int         row_step   = int'(RST_STEP);

    seq_cmd_t  song_cmds[$];
    play_pos_t expected_pos[$];
    int        mismatch_count = 0;
    int        idle_cycles    = 0;
    int        in_gap         = 0;
    bit        in_burst       = 1'b0;
    int        out_wait       = 0;
    bit        out_burst      = 1'b0;

    // row and frame counts: zero counts as one, the top is 256
    function automatic int count_limit(input int v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    function automatic int clip_accum(input int v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return v;
    endfunction

    function automatic void refresh_step();
        row_step = ((tempo * int'(STEP_MUL)) / ((speed != 0) ? speed : 1)) & 'h1FFF;
    endfunction

    // a jump to the frame already playing at row 0 is dropped
    function automatic void arm_jump(input int target);
        if (int'(pos_frame) == target && pos_row == 8'd0) return;
        pend_frame = 8'(target % count_limit(cfg_frame_total));
        pend_row   = 8'd0;
        jump_armed = 1'b1;
    endfunction

    function automatic play_pos_t step_sequencer(input seq_cmd_t c);
        play_pos_t p;
        int        prm;
        int        nxt_row;
        int        nxt_frame;
        p.row_due = 1'b0;
        case (c.opcode)
            OP_TICK: begin
                if (!halted) begin
                    if (accum <= 0) begin
                        accum = clip_accum(accum + int'(RELOAD_MUL) * cfg_frame_rate);
                        p.row_due = 1'b1;
                    end
                    accum = clip_accum(accum - row_step);
                end
            end
            OP_EFFECT: begin
                case (c.kind)
                    FX_SPEED: begin
                        prm = (c.param != 8'd0) ? int'(c.param) : 1;
                        if (prm > cfg_tempo_thr) begin
                            tempo = prm;
                        end else begin
                            speed = prm;
                        end
                        refresh_step();
                    end
                    FX_JUMP: arm_jump(int'(c.param));
                    FX_SKIP: begin
                        arm_jump(int'(pos_frame) + 1);
                        pend_row = c.param;
                    end
                    default: halted = 1'b1;
                endcase
            end
            OP_END_ROW: begin
                if (jump_armed) begin
                    pos_frame  = pend_frame;
                    pos_row    = pend_row;
                    jump_armed = 1'b0;
                end else begin
                    nxt_row = int'(pos_row) + 1;
                    if (nxt_row >= count_limit(cfg_rows)) begin
                        nxt_row   = 0;
                        nxt_frame = int'(pos_frame) + 1;
                        if (nxt_frame >= count_limit(cfg_frame_total)) nxt_frame = 0;
                        pos_frame = 8'(nxt_frame);
                    end
                    pos_row = 8'(nxt_row);
                end
            end
            OP_START: begin
                pos_frame  = 8'(int'(c.sframe) % count_limit(cfg_frame_total));
                pos_row    = 8'(int'(c.srow) % count_limit(cfg_rows));
                jump_armed = 1'b0;
                halted     = 1'b0;
            end
            OP_SET_TEMPO: begin
                tempo = int'(c.ntempo);
                speed = (c.nspeed != 8'd0) ? int'(c.nspeed) : 1;
                accum = 0;
                refresh_step();
            end
            default: ;
        endcase
        p.frame  = pos_frame;
        p.row    = pos_row;
        p.halted = halted;
        return p;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic int draw_wait(input bit burst);
        if (burst) return 0;
        return $urandom_range(MAX_WAIT, 0);
    endfunction

    function automatic void add_cmd(input logic [2:0] op, input t_effect kind,
                                    input logic [7:0] param, input logic [7:0] sframe,
                                    input logic [7:0] srow, input logic [7:0] ntempo,
                                    input logic [7:0] nspeed);
        seq_cmd_t c;
        c.opcode = op;
        c.kind   = kind;
        c.param  = param;
        c.sframe = sframe;
        c.srow   = srow;
        c.ntempo = ntempo;
        c.nspeed = nspeed;
        song_cmds.push_back(c);
    endfunction

    // rows of ticks closed by end of row, with effects, restarts and some noise
    function automatic seq_cmd_t random_cmd();
        seq_cmd_t c;
        int       r;
        int       k;
        r = $urandom_range(99, 0);
        k = $urandom_range(9, 0);
        if (r < 45) c.opcode = OP_TICK;
        else if (r < 60) c.opcode = OP_EFFECT;
        else if (r < 84) c.opcode = OP_END_ROW;
        else if (r < 90) c.opcode = OP_START;
        else if (r < 96) c.opcode = OP_SET_TEMPO;
        else c.opcode = 3'($urandom_range(int'(OP_UNDEF_TOP), int'(OP_SET_TEMPO) + 1));
        // halts kept rare so that ticks keep playing
        c.kind   = (k < 3) ? FX_SPEED : (k < 6) ? FX_JUMP : (k < 9) ? FX_SKIP : FX_HALT;
        c.param  = 8'($urandom_range(255, 0));
        c.sframe = 8'($urandom_range(255, 0));
        c.srow   = 8'($urandom_range(255, 0));
        c.ntempo = 8'($urandom_range(255, 0));
        c.nspeed = 8'($urandom_range(255, 0));
        return c;
    endfunction

    // wait until every pending transfer has come back
    task automatic wait_idle();
        @(negedge i_clk);
        while (song_cmds.size() != 0 || i_s_tvalid || expected_pos.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // apb write followed by a read back of the same register
    task automatic write_register(input logic [1:0] idx, input int value);
        logic [31:0] want;
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= 32'(value);
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_FRAME_RATE: begin
                cfg_frame_rate = value & 'hFF;
                want = 32'(cfg_frame_rate);
            end
            REG_PATTERN_ROWS: begin
                cfg_rows = value & 'h1FF;
                want = 32'(cfg_rows);
            end
            REG_FRAME_TOTAL: begin
                cfg_frame_total = value & 'h1FF;
                want = 32'(cfg_frame_total);
            end
            default: begin
                cfg_tempo_thr = value & 'hFF;
                want = 32'(cfg_tempo_thr);
            end
        endcase
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        check_field("register read back", want, o_prdata);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    // input driver
    always @(posedge i_clk) begin
        seq_cmd_t c;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            in_gap     <= 0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (in_gap != 0) begin
                i_s_tvalid <= 1'b0;
                in_gap     <= in_gap - 1;
            end else if (song_cmds.size() != 0) begin
                c = song_cmds.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {c.nspeed, c.ntempo, c.srow, c.sframe, c.param};
                i_s_tuser  <= {c.kind, c.opcode};
                if ($urandom_range(49, 0) == 0) in_burst = !in_burst;
                in_gap <= draw_wait(in_burst);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure, drawn afresh after each transfer
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            out_wait   <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if ($urandom_range(49, 0) == 0) out_burst = !out_burst;
                w = draw_wait(out_burst);
            end else if (o_m_tvalid && out_wait != 0) begin
                w = out_wait - 1;
            end else begin
                w = out_wait;
            end
            i_m_tready <= (w == 0);
            out_wait   <= w;
        end
    end

    // monitor: check results against the oldest prediction, then predict new input
    always @(posedge i_clk) begin
        seq_cmd_t  c;
        play_pos_t want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_pos.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, actual frame %0d row %0d",
                             $time, o_m_tdata[7:0], o_m_tdata[15:8]);
                    mismatch_count++;
                end else begin
                    want = expected_pos.pop_front();
                    check_field("row_due", 32'(want.row_due), 32'(o_m_tuser[0]));
                    check_field("is_halted", 32'(want.halted), 32'(o_m_tuser[1]));
                    check_field("play_frame", 32'(want.frame), 32'(o_m_tdata[7:0]));
                    check_field("play_row", 32'(want.row), 32'(o_m_tdata[15:8]));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                c.opcode = i_s_tuser[2:0];
                c.kind   = t_effect'(i_s_tuser[4:3]);
                c.param  = i_s_tdata[7:0];
                c.sframe = i_s_tdata[15:8];
                c.srow   = i_s_tdata[23:16];
                c.ntempo = i_s_tdata[31:24];
                c.nspeed = i_s_tdata[39:32];
                expected_pos.push_back(step_sequencer(c));
            end
        end
    end

    // watchdog on cycles with no transfer on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_psel && i_penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus and end of run
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed sequence at the reset settings
        add_cmd(OP_TICK, FX_SPEED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        add_cmd(OP_TICK, FX_SPEED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        // start past the ends of both counts
        add_cmd(OP_START, FX_SPEED, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0);
        add_cmd(OP_END_ROW, FX_SPEED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        // jump to the frame already playing at row 0
        add_cmd(OP_EFFECT, FX_JUMP, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        // zero speed parameter, then either side of the threshold
        add_cmd(OP_EFFECT, FX_SPEED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        add_cmd(OP_EFFECT, FX_SPEED, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
        add_cmd(OP_EFFECT, FX_SPEED, 8'd31, 8'd0, 8'd0, 8'd0, 8'd0);
        add_cmd(OP_EFFECT, FX_SPEED, 8'd32, 8'd0, 8'd0, 8'd0, 8'd0);
        // set tempo with zero speed
        add_cmd(OP_SET_TEMPO, FX_SPEED, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0);
        add_cmd(OP_TICK, FX_SPEED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        add_cmd(OP_TICK, FX_SPEED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        // two requests in one row, the later one wins
        add_cmd(OP_EFFECT, FX_SKIP, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
        add_cmd(OP_EFFECT, FX_JUMP, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
        add_cmd(OP_END_ROW, FX_SPEED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        // skip to a row past the pattern end, then let it wrap
        add_cmd(OP_EFFECT, FX_SKIP, 8'd200, 8'd0, 8'd0, 8'd0, 8'd0);
        add_cmd(OP_END_ROW, FX_SPEED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        add_cmd(OP_END_ROW, FX_SPEED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        // halted: ticks suppressed, everything else still acts
        add_cmd(OP_EFFECT, FX_HALT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        add_cmd(OP_TICK, FX_SPEED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        add_cmd(OP_END_ROW, FX_SPEED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        add_cmd(OP_UNDEF_TOP, FX_HALT, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        add_cmd(OP_SET_TEMPO, FX_SPEED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
        add_cmd(OP_START, FX_SPEED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        add_cmd(OP_TICK, FX_SPEED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        wait_idle();

        // random phases, the first at the reset settings
        for (int ph = 0; ph <= 6; ph++) begin
            if (ph != 0) begin
                write_register(REG_FRAME_RATE, PHASE_CFG[ph - 1][0]);
                write_register(REG_PATTERN_ROWS, PHASE_CFG[ph - 1][1]);
                write_register(REG_FRAME_TOTAL, PHASE_CFG[ph - 1][2]);
                write_register(REG_TEMPO_THR, PHASE_CFG[ph - 1][3]);
            end
            repeat (PHASE_ITEMS) song_cmds.push_back(random_cmd());
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_pos.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/trs_pkg.sv
rtl/core/tracker_row_sequencer_unit.sv
dv/tracker_row_sequencer_unit_tb.sv
